### rtl/core/dqr_pkg.sv
// Shared types and constants for the deque with remove-by-value.
`default_nettype none
package dqr_pkg;

    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam int DEF_CAPACITY    = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_REMOVE     = 3'd4
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_UPD  = 2'd1,
        S_RES  = 2'd2
    } t_state;

    typedef struct packed {
        logic capture;
        logic update;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_valid;
    } t_dp_sts;

endpackage
`default_nettype wire

### rtl/core/dqr_if.sv
// Operation and result channel interfaces.
`default_nettype none
interface dqr_op_if;
    logic                          valid;
    logic                          ready;
    logic [dqr_pkg::ACTION_W-1:0]  action;
    logic [dqr_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface dqr_res_if;
    logic                          valid;
    logic                          ready;
    logic [dqr_pkg::STATUS_W-1:0]  status;
    logic [dqr_pkg::VALUE_W-1:0]   first_value;
    logic [dqr_pkg::VALUE_W-1:0]   last_value;
    logic [dqr_pkg::COUNT_W-1:0]   count;
    logic                          is_empty_flag;

    modport source (output valid, output status, output first_value, output last_value,
                    output count, output is_empty_flag, input ready);
    modport sink   (input valid, input status, input first_value, input last_value,
                    input count, input is_empty_flag, output ready);
endinterface
`default_nettype wire

### rtl/core/dqr_datapath.sv
// Datapath: shifting cell row with per-cell compare, count and result register.
`default_nettype none
module dqr_datapath #(
    parameter int CAPACITY    = dqr_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = dqr_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire dqr_pkg::t_dp_cmd              i_cmd,
    output dqr_pkg::t_dp_sts                   o_sts,
    input  wire logic [dqr_pkg::ACTION_W-1:0]  i_action,
    input  wire logic [dqr_pkg::VALUE_W-1:0]   i_value,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [dqr_pkg::STATUS_W-1:0]       o_status,
    output logic [dqr_pkg::VALUE_W-1:0]        o_first_value,
    output logic [dqr_pkg::VALUE_W-1:0]        o_last_value,
    output logic [dqr_pkg::COUNT_W-1:0]        o_count,
    output logic                               o_is_empty_flag
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [VALUE_WIDTH-1:0]        r_cell [CAPACITY];
    logic [CNT_W-1:0]              r_count;
    logic [VALUE_WIDTH-1:0]        r_key;
    logic [dqr_pkg::ACTION_W-1:0]  r_action;
    logic [CAPACITY-1:0]           r_match;

    logic                          r_out_valid;
    logic [dqr_pkg::STATUS_W-1:0]  r_out_status;
    logic [dqr_pkg::VALUE_W-1:0]   r_out_first;
    logic [dqr_pkg::VALUE_W-1:0]   r_out_last;
    logic [dqr_pkg::COUNT_W-1:0]   r_out_count;
    logic                          r_out_empty;
    dqr_pkg::t_status              r_status;

    logic [VALUE_WIDTH-1:0]        w_key_in;
    logic [CAPACITY-1:0]           w_match;
    logic [CAPACITY-1:0]           w_shift;
    logic                          w_full;
    logic                          w_empty;
    dqr_pkg::t_status              w_status;
    logic                          w_do;
    logic [CNT_W-1:0]              w_last_pos;
    logic [VALUE_WIDTH-1:0]        w_last_cell;
    logic [dqr_pkg::VALUE_W-1:0]   w_first_port;
    logic [dqr_pkg::VALUE_W-1:0]   w_last_port;
    logic [dqr_pkg::COUNT_W-1:0]   w_count_port;

    generate
        if (VALUE_WIDTH <= dqr_pkg::VALUE_W) begin : g_narrow
            assign w_key_in = i_value[VALUE_WIDTH-1:0];
        end else begin : g_wide
            assign w_key_in = {{(VALUE_WIDTH - dqr_pkg::VALUE_W){1'b0}}, i_value};
        end
        if (VALUE_WIDTH >= dqr_pkg::VALUE_W) begin : g_out_trunc
            assign w_first_port = r_cell[0][dqr_pkg::VALUE_W-1:0];
            assign w_last_port  = w_last_cell[dqr_pkg::VALUE_W-1:0];
        end else begin : g_out_ext
            assign w_first_port = {{(dqr_pkg::VALUE_W - VALUE_WIDTH){1'b0}}, r_cell[0]};
            assign w_last_port  = {{(dqr_pkg::VALUE_W - VALUE_WIDTH){1'b0}}, w_last_cell};
        end
        if (CNT_W >= dqr_pkg::COUNT_W) begin : g_cnt_trunc
            assign w_count_port = r_count[dqr_pkg::COUNT_W-1:0];
        end else begin : g_cnt_ext
            assign w_count_port = {{(dqr_pkg::COUNT_W - CNT_W){1'b0}}, r_count};
        end
    endgenerate

    // per-cell compare against the incoming key, live cells only
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_match[i] = (CNT_W'(i) < r_count) && (r_cell[i] == w_key_in);
        end
    end

    // cells at and after the first hit move one place toward the front
    always_comb begin
        logic acc;
        acc = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            acc        = acc | r_match[i];
            w_shift[i] = acc;
        end
    end

    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);

    always_comb begin
        case (r_action)
            dqr_pkg::ACT_PUSH_FRONT,
            dqr_pkg::ACT_PUSH_BACK: begin
                w_status = w_full ? dqr_pkg::ST_FULL : dqr_pkg::ST_OK;
            end
            dqr_pkg::ACT_POP_FRONT,
            dqr_pkg::ACT_POP_BACK: begin
                w_status = w_empty ? dqr_pkg::ST_EMPTY : dqr_pkg::ST_OK;
            end
            dqr_pkg::ACT_REMOVE: begin
                if (w_empty) begin
                    w_status = dqr_pkg::ST_EMPTY;
                end else if (!w_shift[CAPACITY-1]) begin
                    w_status = dqr_pkg::ST_NOT_FOUND;
                end else begin
                    w_status = dqr_pkg::ST_OK;
                end
            end
            default: w_status = dqr_pkg::ST_OK;
        endcase
    end

    assign w_do = i_cmd.update && (w_status == dqr_pkg::ST_OK);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_key    <= w_key_in;
            r_action <= i_action;
            r_match  <= w_match;
        end
        if (i_cmd.update) begin
            r_status <= w_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do) begin
            case (r_action)
                dqr_pkg::ACT_PUSH_FRONT: begin
                    r_cell[0] <= r_key;
                    for (int i = 1; i < CAPACITY; i++) begin
                        r_cell[i] <= r_cell[i-1];
                    end
                end
                dqr_pkg::ACT_PUSH_BACK: begin
                    r_cell[r_count[IDX_W-1:0]] <= r_key;
                end
                dqr_pkg::ACT_POP_FRONT: begin
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        r_cell[i] <= r_cell[i+1];
                    end
                end
                dqr_pkg::ACT_REMOVE: begin
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        if (w_shift[i]) begin
                            r_cell[i] <= r_cell[i+1];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_do) begin
            case (r_action)
                dqr_pkg::ACT_PUSH_FRONT,
                dqr_pkg::ACT_PUSH_BACK:  r_count <= r_count + CNT_W'(1);
                dqr_pkg::ACT_POP_FRONT,
                dqr_pkg::ACT_POP_BACK,
                dqr_pkg::ACT_REMOVE:     r_count <= r_count - CNT_W'(1);
                default: ;
            endcase
        end
    end

    assign w_last_pos  = r_count - CNT_W'(1);
    assign w_last_cell = r_cell[w_last_pos[IDX_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_first  <= w_empty ? '0 : w_first_port;
            r_out_last   <= w_empty ? '0 : w_last_port;
            r_out_count  <= w_count_port;
            r_out_empty  <= w_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_valid = r_out_valid;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_first_value   = r_out_first;
    assign o_last_value    = r_out_last;
    assign o_count         = r_out_count;
    assign o_is_empty_flag = r_out_empty;

endmodule
`default_nettype wire

### rtl/core/dqr_ctrl.sv
// Controller: sequences capture, update and result load for each operation.
`default_nettype none
module dqr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_out_ready,
    input  wire dqr_pkg::t_dp_sts  i_sts,
    output dqr_pkg::t_dp_cmd       o_cmd
);

    dqr_pkg::t_state r_state;
    dqr_pkg::t_state n_state;
    logic            w_out_free;

    assign w_out_free = !i_sts.out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dqr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            dqr_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = dqr_pkg::S_UPD;
                end
            end
            dqr_pkg::S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = dqr_pkg::S_RES;
            end
            dqr_pkg::S_RES: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_in_ready     = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.capture = 1'b1;
                        n_state       = dqr_pkg::S_UPD;
                    end else begin
                        n_state = dqr_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = dqr_pkg::S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

### rtl/core/deque_with_remove_by_value.sv
// Top level: double-ended key queue with remove of the first matching key.
//
// Channels: i_op takes one operation per transfer (action, value); o_res
// gives exactly one result per operation, in order (status, first and last
// key, count, empty flag).
// Steps: the capture compares the key in live cells, the update state shifts
// the cell row and updates the count, and the result register loads, once o_res
// is free, in the result state that also takes the next operation; the result
// is then offered on o_res. No operation is taken during the update state.
// Reset (synchronous, active low) empties the queue and drops any pending
// result; cell contents are not cleared.
// When o_res stalls, the finished result is held and one more operation is
// taken and executed; i_op then holds ready low until the result is taken.
`default_nettype none
module deque_with_remove_by_value #(
    parameter int CAPACITY    = dqr_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = dqr_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dqr_op_if.sink      i_op,
    dqr_res_if.source   o_res
);

    dqr_pkg::t_dp_cmd w_cmd;
    dqr_pkg::t_dp_sts w_sts;

    dqr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_op.valid),
        .o_in_ready  (i_op.ready),
        .i_out_ready (o_res.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    dqr_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_action        (i_op.action),
        .i_value         (i_op.value),
        .i_out_ready     (o_res.ready),
        .o_out_valid     (o_res.valid),
        .o_status        (o_res.status),
        .o_first_value   (o_res.first_value),
        .o_last_value    (o_res.last_value),
        .o_count         (o_res.count),
        .o_is_empty_flag (o_res.is_empty_flag)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op.valid && i_op.ready) |=> !i_op.ready)
        else $error("operation taken during update cycle");

    a_empty_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.is_empty_flag) |->
            (o_res.first_value == '0 && o_res.last_value == '0))
        else $error("empty result with nonzero keys");

    a_result_follows_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op.valid && i_op.ready) |=> ##1 (w_sts.out_valid || w_cmd.load_out))
        else $error("result slot not loading after operation");

    a_empty_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.is_empty_flag) |-> (o_res.count == '0))
        else $error("empty result with nonzero count");

endmodule
`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the deque with remove-by-value: queued stimulus, scoreboard.
`default_nettype none
module testbench;

    localparam int ACTION_W    = dqr_pkg::ACTION_W;
    localparam int VALUE_W     = dqr_pkg::VALUE_W;
    localparam int COUNT_W     = dqr_pkg::COUNT_W;
    localparam int DEPTH       = dqr_pkg::DEF_CAPACITY;
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 150;
    localparam int RAND_ITEMS  = 1870;

    // action codes with no defined operation
    localparam logic [ACTION_W-1:0] ACT_UNDEF_LO = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_UNDEF_HI = 3'd7;

    typedef struct {
        logic [ACTION_W-1:0] act;
        logic [VALUE_W-1:0]  key;
    } t_op_item;

    typedef struct {
        dqr_pkg::t_status   status;
        logic [VALUE_W-1:0] first_key;
        logic [VALUE_W-1:0] last_key;
        logic [COUNT_W-1:0] cnt;
        logic               empty;
    } t_snapshot;

    logic i_clk;
    logic i_rst_n;

    dqr_op_if  op_if ();
    dqr_res_if res_if ();

    deque_with_remove_by_value u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op_if),
        .o_res   (res_if)
    );

    t_op_item           ops_to_send[$];
    t_snapshot          snapshots_due[$];
    logic [VALUE_W-1:0] held_keys[$];

    int ops_done;
    int results_checked;
    int errors;
    int full_seen;
    int empty_seen;
    int miss_seen;
    int remove_hits;
    int undefined_seen;
    bit hold_done[2];

    logic [VALUE_W-1:0] key_pool[12] = '{
        32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
        32'h0000_0005, 32'h0000_0008, 32'hFFFF_FFFF, 32'h8000_0000,
        32'h7FFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0000_FFFF
    };

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // deque behavior, applied at each accepted operation
    task automatic apply_deque_op(input logic [ACTION_W-1:0] act,
                                  input logic [VALUE_W-1:0] key);
        t_snapshot snap;
        int        hit_at;
        snap.status = dqr_pkg::ST_OK;
        hit_at      = -1;
        case (act)
            dqr_pkg::ACT_PUSH_FRONT, dqr_pkg::ACT_PUSH_BACK: begin
                if (held_keys.size() >= DEPTH) begin
                    snap.status = dqr_pkg::ST_FULL;
                    full_seen++;
                end else if (act == dqr_pkg::ACT_PUSH_FRONT) begin
                    held_keys.push_front(key);
                end else begin
                    held_keys.push_back(key);
                end
            end
            dqr_pkg::ACT_POP_FRONT, dqr_pkg::ACT_POP_BACK, dqr_pkg::ACT_REMOVE: begin
                if (held_keys.size() == 0) begin
                    snap.status = dqr_pkg::ST_EMPTY;
                    empty_seen++;
                end else if (act == dqr_pkg::ACT_POP_FRONT) begin
                    void'(held_keys.pop_front());
                end else if (act == dqr_pkg::ACT_POP_BACK) begin
                    void'(held_keys.pop_back());
                end else begin
                    for (int i = 0; i < held_keys.size(); i++) begin
                        if (held_keys[i] == key) begin
                            hit_at = i;
                            break;
                        end
                    end
                    if (hit_at < 0) begin
                        snap.status = dqr_pkg::ST_NOT_FOUND;
                        miss_seen++;
                    end else begin
                        held_keys.delete(hit_at);
                        remove_hits++;
                    end
                end
            end
            default: undefined_seen++;
        endcase
        snap.cnt   = COUNT_W'(held_keys.size());
        snap.empty = (held_keys.size() == 0);
        if (held_keys.size() == 0) begin
            snap.first_key = '0;
            snap.last_key  = '0;
        end else begin
            snap.first_key = held_keys[0];
            snap.last_key  = held_keys[held_keys.size() - 1];
        end
        snapshots_due.push_back(snap);
    endtask

    task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    task automatic queue_op(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] key);
        t_op_item item;
        item.act = act;
        item.key = key;
        ops_to_send.push_back(item);
    endtask

    function automatic logic [VALUE_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 70)
            return key_pool[$urandom_range(0, 11)];
        return $urandom;
    endfunction

    // profile: 0 fill, 1 drain, 2 remove-heavy, 3 uniform
    function automatic logic [ACTION_W-1:0] pick_action(input int profile);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return ACTION_W'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
        r = $urandom_range(0, 99);
        case (profile)
            0: begin
                if (r < 85)
                    return $urandom_range(0, 1) ? dqr_pkg::ACT_PUSH_BACK
                                                : dqr_pkg::ACT_PUSH_FRONT;
                if (r < 93) return dqr_pkg::ACT_REMOVE;
                return $urandom_range(0, 1) ? dqr_pkg::ACT_POP_BACK : dqr_pkg::ACT_POP_FRONT;
            end
            1: begin
                if (r < 80)
                    return $urandom_range(0, 1) ? dqr_pkg::ACT_POP_BACK
                                                : dqr_pkg::ACT_POP_FRONT;
                if (r < 90) return dqr_pkg::ACT_REMOVE;
                return dqr_pkg::ACT_PUSH_BACK;
            end
            2: begin
                if (r < 55) return dqr_pkg::ACT_REMOVE;
                if (r < 85)
                    return $urandom_range(0, 1) ? dqr_pkg::ACT_PUSH_BACK
                                                : dqr_pkg::ACT_PUSH_FRONT;
                return dqr_pkg::ACT_POP_FRONT;
            end
            default: return ACTION_W'($urandom_range(dqr_pkg::ACT_PUSH_FRONT,
                                                      dqr_pkg::ACT_REMOVE));
        endcase
    endfunction

    function automatic bit calm_window();
        return ((ops_done / 200) % 4) == 3;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_window() || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // operation driver
    int       send_gap;
    t_op_item next_op;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            op_if.valid  <= 1'b0;
            op_if.action <= '0;
            op_if.value  <= '0;
            send_gap = 0;
        end else if (!op_if.valid || op_if.ready) begin
            if (send_gap > 0) begin
                send_gap--;
                op_if.valid <= 1'b0;
            end else if (ops_to_send.size() > 0) begin
                next_op = ops_to_send.pop_front();
                op_if.valid  <= 1'b1;
                op_if.action <= next_op.act;
                op_if.value  <= next_op.key;
                send_gap = pick_gap();
            end else begin
                op_if.valid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls and two long hold-offs
    int stall_left;
    int r_ready;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            res_if.ready <= 1'b0;
        end else if ((ops_done >= 500 && !hold_done[0]) || (ops_done >= 1300 && !hold_done[1])) begin
            if (!hold_done[0]) hold_done[0] = 1'b1;
            else               hold_done[1] = 1'b1;
            stall_left = HOLD_CYCLES - 1;
            res_if.ready <= 1'b0;
        end else begin
            r_ready = $urandom_range(0, 99);
            if (calm_window() || r_ready < 70) begin
                res_if.ready <= 1'b1;
            end else begin
                stall_left = (r_ready < 97) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                res_if.ready <= 1'b0;
            end
        end
    end

    // operation transfers feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && op_if.valid && op_if.ready) begin
            apply_deque_op(op_if.action, op_if.value);
            ops_done++;
        end
    end

    // result checker
    t_snapshot want;
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (snapshots_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual status %0d count %0d",
                         $time, res_if.status, res_if.count);
            end else begin
                want = snapshots_due.pop_front();
                check_field("status", VALUE_W'(want.status), VALUE_W'(res_if.status));
                check_field("first_value", want.first_key, res_if.first_value);
                check_field("last_value", want.last_key, res_if.last_value);
                check_field("count", VALUE_W'(want.cnt), VALUE_W'(res_if.count));
                check_field("is_empty_flag", VALUE_W'(want.empty), VALUE_W'(res_if.is_empty_flag));
                results_checked++;
            end
        end
    end

    // watchdog: ends the run after too long without any transfer
    int idle_cycles;
    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((op_if.valid && op_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, IDLE_LIMIT, snapshots_due.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int profile;
        int run_len;
        int queued;
        op_if.valid  = 1'b0;
        op_if.action = '0;
        op_if.value  = '0;
        res_if.ready = 1'b0;
        i_rst_n      = 1'b0;

        // empty queue: pops, remove, undefined code
        queue_op(dqr_pkg::ACT_POP_FRONT, 32'h0000_0000);
        queue_op(dqr_pkg::ACT_POP_BACK, 32'hFFFF_FFFF);
        queue_op(dqr_pkg::ACT_REMOVE, 32'h0000_0000);
        queue_op(ACT_UNDEF_HI, 32'hFFFF_FFFF);
        // fill to capacity from both ends, with a duplicate key
        queue_op(dqr_pkg::ACT_PUSH_BACK, 32'hFFFF_FFFF);
        queue_op(dqr_pkg::ACT_PUSH_FRONT, 32'h0000_0000);
        for (int i = 0; i < DEPTH - 2; i++)
            queue_op(i[0] ? dqr_pkg::ACT_PUSH_FRONT : dqr_pkg::ACT_PUSH_BACK,
                     (i == 3 || i == 8) ? 32'h0000_00A5 : 32'h1 << (i * 2 + 1));
        queue_op(dqr_pkg::ACT_PUSH_FRONT, 32'h8000_0000);
        queue_op(dqr_pkg::ACT_PUSH_BACK, 32'h7FFF_FFFF);
        queue_op(dqr_pkg::ACT_REMOVE, 32'h1234_5678);
        queue_op(dqr_pkg::ACT_REMOVE, 32'h0000_00A5);
        queue_op(ACT_UNDEF_LO, 32'h0000_0000);
        queue_op(dqr_pkg::ACT_POP_FRONT, 32'h0000_0000);
        queue_op(dqr_pkg::ACT_POP_BACK, 32'h0000_0000);
        queue_op(ACT_UNDEF_LO, 32'h5555_5555);

        queued = 0;
        while (queued < RAND_ITEMS) begin
            profile = $urandom_range(0, 3);
            run_len = $urandom_range(10, 60);
            for (int i = 0; i < run_len; i++)
                queue_op(pick_action(profile), pick_key());
            queued += run_len;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (ops_to_send.size() != 0 || op_if.valid || snapshots_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Ran %0d operations, checked %0d results (%0d removes hit, %0d not found)",
                 ops_done, results_checked, remove_hits, miss_seen);
        $display("Saw %0d full pushes, %0d empty pops/removes, %0d undefined codes",
                 full_seen, empty_seen, undefined_seen);
        if (errors == 0 && snapshots_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
`default_nettype wire
